// File: hw/rtl/gjk_pkg.sv
package gjk_pkg;

    localparam int MAX_VERTS_DEF = 16;
    localparam int MAX_ITER_DEF  = 32;

    // vertex coordinate width
    localparam int VW = 16;
    // support point coordinate width (difference of two vertices)
    localparam int PW = VW + 1;
    // edge vector / perpendicular width
    localparam int EW = VW + 2;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    typedef enum logic [1:0] {
        OP_ADD_FIRST  = 2'd0,
        OP_ADD_SECOND = 2'd1,
        OP_CHECK      = 2'd2,
        OP_NONE       = 2'd3
    } opcode_t;

endpackage

// File: hw/rtl/gjk_convex_polygon_overlap_core.sv
// channel | dir | tdata fields (lsb first)                  | note
// s_      | in  | opcode[1:0] vx[17:2] vy[33:18], pad to 40  | load vertex or run check
// m_      | out | overlap[0] gave_up[1] dropped[2], pad to 8 | one per check
//
// a vertex load does not leave the idle state; a check is sequenced through
// the single shared multiply-accumulate unit and the vertex store read port
// s_tready is low while a check runs; its last step waits until the output register is free
// aresetn clears counts, flags and the sequencer; vertex stores are not cleared
module gjk_convex_polygon_overlap_core
    import gjk_pkg::*;
#(
    parameter int MAX_VERTS = MAX_VERTS_DEF,
    parameter int MAX_ITER  = MAX_ITER_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // opcode, vx, vy
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // overlap, gave_up, dropped
);

    localparam int CW  = $clog2(MAX_VERTS + 1);
    localparam int AIW = $clog2(MAX_VERTS);
    localparam int IW  = $clog2(MAX_ITER + 1);
    localparam int SW  = VW + AIW;
    localparam int DW  = CW + SW + 2;
    localparam int PRW = DW + EW;
    localparam int AW  = DW + EW + 1;

    typedef enum logic [27:0] {
        S_IDLE    = 28'd1 << 0,
        S_CHK     = 28'd1 << 1,
        S_SUM_RD  = 28'd1 << 2,
        S_SUM_ACC = 28'd1 << 3,
        S_DX0     = 28'd1 << 4,
        S_DX1     = 28'd1 << 5,
        S_DY0     = 28'd1 << 6,
        S_DY1     = 28'd1 << 7,
        S_IT      = 28'd1 << 8,
        S_SUP_RD  = 28'd1 << 9,
        S_SUP_MX  = 28'd1 << 10,
        S_SUP_MY  = 28'd1 << 11,
        S_PCHK    = 28'd1 << 12,
        S_DOT0    = 28'd1 << 13,
        S_DOT1    = 28'd1 << 14,
        S_LN0     = 28'd1 << 15,
        S_LN1     = 28'd1 << 16,
        S_LN2     = 28'd1 << 17,
        S_TR0     = 28'd1 << 18,
        S_TR1     = 28'd1 << 19,
        S_TR2     = 28'd1 << 20,
        S_TR3     = 28'd1 << 21,
        S_TR4     = 28'd1 << 22,
        S_TR5     = 28'd1 << 23,
        S_TR6     = 28'd1 << 24,
        S_TR7     = 28'd1 << 25,
        S_TR8     = 28'd1 << 26,
        S_FIN     = 28'd1 << 27
    } state_t;

    state_t state_reg;

    logic [2*VW-1:0] mem1 [MAX_VERTS];
    logic [2*VW-1:0] mem2 [MAX_VERTS];
    logic [2*VW-1:0] rd1_reg, rd2_reg;

    logic [CW-1:0] cnt1_reg, cnt2_reg, idx_reg;
    logic [IW-1:0] iter_reg;
    logic          dropped_reg, sel_reg, first_reg;
    logic          res_ovl_reg, res_gave_reg;
    logic          m_valid_reg;
    logic [2:0]    m_data_reg;
    logic [1:0]    ssize_reg;

    logic signed [SW-1:0] s1x_reg, s1y_reg, s2x_reg, s2y_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [AW-1:0] acc_reg, bdot_reg;
    logic signed [VW-1:0] bx_reg, by_reg, sup2x_reg, sup2y_reg;
    logic signed [PW-1:0] px_reg, py_reg;
    logic signed [PW-1:0] p0x_reg, p0y_reg, p1x_reg, p1y_reg, p2x_reg, p2y_reg;
    logic signed [EW-1:0] abx_reg, aby_reg, acx_reg, acy_reg;
    logic signed [EW-1:0] ux_reg, uy_reg, vx_reg, vy_reg;

    opcode_t              in_op;
    logic signed [VW-1:0] in_vx, in_vy;
    logic                 s_acc;

    logic signed [VW-1:0] rdx, rdy, bx_new, by_new;
    logic                 last_vert, take_best;
    logic signed [DW-1:0]  mul_a;
    logic signed [EW-1:0]  mul_b;
    logic signed [PRW-1:0] prod;
    logic                  mul_clr, mul_sub;
    logic signed [AW-1:0]  mac;
    logic                  mac_neg, mac_zero, mac_pos;
    logic signed [EW-1:0]  t_abx, t_aby, t_acx, t_acy;

    assign in_op  = opcode_t'(s_tdata[1:0]);
    assign in_vx  = s_tdata[VW+1:2];
    assign in_vy  = s_tdata[2*VW+1:VW+2];
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-3){1'b0}}, m_data_reg};

    always_ff @(posedge aclk) begin
        rd1_reg <= mem1[idx_reg[AIW-1:0]];
        rd2_reg <= mem2[idx_reg[AIW-1:0]];
        if (s_acc && in_op == OP_ADD_FIRST && cnt1_reg < CW'(MAX_VERTS)) begin
            mem1[cnt1_reg[AIW-1:0]] <= {in_vy, in_vx};
        end
        if (s_acc && in_op == OP_ADD_SECOND && cnt2_reg < CW'(MAX_VERTS)) begin
            mem2[cnt2_reg[AIW-1:0]] <= {in_vy, in_vx};
        end
    end

    assign rdx = sel_reg ? rd2_reg[VW-1:0] : rd1_reg[VW-1:0];
    assign rdy = sel_reg ? rd2_reg[2*VW-1:VW] : rd1_reg[2*VW-1:VW];
    assign last_vert = (CW'(idx_reg + 1'b1) == (sel_reg ? cnt2_reg : cnt1_reg));

    // shared multiply-accumulate operand selection
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_clr = 1'b0;
        mul_sub = 1'b0;
        unique case (state_reg)
            S_DX0: begin
                mul_a = DW'(s2x_reg); mul_b = EW'(cnt1_reg); mul_clr = 1'b1;
            end
            S_DX1: begin
                mul_a = DW'(s1x_reg); mul_b = EW'(cnt2_reg); mul_sub = 1'b1;
            end
            S_DY0: begin
                mul_a = DW'(s2y_reg); mul_b = EW'(cnt1_reg); mul_clr = 1'b1;
            end
            S_DY1: begin
                mul_a = DW'(s1y_reg); mul_b = EW'(cnt2_reg); mul_sub = 1'b1;
            end
            S_SUP_MX: begin
                mul_a = dx_reg; mul_b = EW'(rdx); mul_clr = 1'b1; mul_sub = !sel_reg;
            end
            S_SUP_MY: begin
                mul_a = dy_reg; mul_b = EW'(rdy); mul_sub = !sel_reg;
            end
            S_DOT0: begin
                mul_a = dx_reg; mul_b = EW'(px_reg); mul_clr = 1'b1;
            end
            S_DOT1: begin
                mul_a = dy_reg; mul_b = EW'(py_reg);
            end
            S_LN1: begin
                mul_a = DW'(aby_reg); mul_b = EW'(p1x_reg); mul_clr = 1'b1;
            end
            S_LN2: begin
                mul_a = DW'(abx_reg); mul_b = EW'(p1y_reg); mul_sub = 1'b1;
            end
            S_TR1: begin
                mul_a = DW'(ux_reg); mul_b = acx_reg; mul_clr = 1'b1;
            end
            S_TR2: begin
                mul_a = DW'(uy_reg); mul_b = acy_reg;
            end
            S_TR3: begin
                mul_a = DW'(vx_reg); mul_b = abx_reg; mul_clr = 1'b1;
            end
            S_TR4: begin
                mul_a = DW'(vy_reg); mul_b = aby_reg;
            end
            S_TR5: begin
                mul_a = DW'(ux_reg); mul_b = EW'(p2x_reg); mul_clr = 1'b1; mul_sub = 1'b1;
            end
            S_TR6: begin
                mul_a = DW'(uy_reg); mul_b = EW'(p2y_reg); mul_sub = 1'b1;
            end
            S_TR7: begin
                mul_a = DW'(vx_reg); mul_b = EW'(p2x_reg); mul_clr = 1'b1; mul_sub = 1'b1;
            end
            S_TR8: begin
                mul_a = DW'(vy_reg); mul_b = EW'(p2y_reg); mul_sub = 1'b1;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;
    assign mac  = (mul_clr ? AW'(0) : acc_reg) + (mul_sub ? -AW'(prod) : AW'(prod));
    assign mac_neg  = mac[AW-1];
    assign mac_zero = (mac == '0);
    assign mac_pos  = !mac_neg && !mac_zero;

    // lowest index wins on ties
    assign take_best = (idx_reg == '0) || (mac > bdot_reg);
    assign bx_new = take_best ? rdx : bx_reg;
    assign by_new = take_best ? rdy : by_reg;

    assign t_abx = EW'(p1x_reg) - EW'(p2x_reg);
    assign t_aby = EW'(p1y_reg) - EW'(p2y_reg);
    assign t_acx = EW'(p0x_reg) - EW'(p2x_reg);
    assign t_acy = EW'(p0y_reg) - EW'(p2y_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt1_reg     <= '0;
            cnt2_reg     <= '0;
            idx_reg      <= '0;
            iter_reg     <= '0;
            dropped_reg  <= 1'b0;
            sel_reg      <= 1'b0;
            first_reg    <= 1'b0;
            ssize_reg    <= '0;
            res_ovl_reg  <= 1'b0;
            res_gave_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            // in S_FIN the output register is reloaded instead
            if (m_valid_reg && m_tready && state_reg != S_FIN) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        unique case (in_op)
                            OP_ADD_FIRST: begin
                                if (cnt1_reg < CW'(MAX_VERTS)) cnt1_reg <= cnt1_reg + 1'b1;
                                else dropped_reg <= 1'b1;
                            end
                            OP_ADD_SECOND: begin
                                if (cnt2_reg < CW'(MAX_VERTS)) cnt2_reg <= cnt2_reg + 1'b1;
                                else dropped_reg <= 1'b1;
                            end
                            OP_CHECK: state_reg <= S_CHK;
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_CHK: begin
                    ssize_reg <= '0;
                    s1x_reg <= '0; s1y_reg <= '0; s2x_reg <= '0; s2y_reg <= '0;
                    idx_reg <= '0;
                    sel_reg <= 1'b0;
                    if (cnt1_reg == '0 || cnt2_reg == '0) begin
                        res_ovl_reg  <= 1'b0;
                        res_gave_reg <= 1'b0;
                        state_reg    <= S_FIN;
                    end else begin
                        state_reg <= S_SUM_RD;
                    end
                end
                S_SUM_RD: state_reg <= S_SUM_ACC;
                S_SUM_ACC: begin
                    if (sel_reg) begin
                        s2x_reg <= s2x_reg + SW'(rdx);
                        s2y_reg <= s2y_reg + SW'(rdy);
                    end else begin
                        s1x_reg <= s1x_reg + SW'(rdx);
                        s1y_reg <= s1y_reg + SW'(rdy);
                    end
                    if (last_vert) begin
                        idx_reg   <= '0;
                        sel_reg   <= 1'b1;
                        state_reg <= sel_reg ? S_DX0 : S_SUM_RD;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SUM_RD;
                    end
                end
                S_DX0: begin
                    acc_reg <= mac; state_reg <= S_DX1;
                end
                S_DX1: begin
                    dx_reg <= DW'(mac); state_reg <= S_DY0;
                end
                S_DY0: begin
                    acc_reg <= mac; state_reg <= S_DY1;
                end
                S_DY1: begin
                    dy_reg <= DW'(mac);
                    if (dx_reg == '0 && DW'(mac) == '0) dx_reg <= DW'(1);
                    first_reg <= 1'b1;
                    idx_reg   <= '0;
                    sel_reg   <= 1'b1;
                    state_reg <= S_SUP_RD;
                end
                S_IT: begin
                    if (iter_reg == IW'(MAX_ITER)) begin
                        res_ovl_reg  <= 1'b0;
                        res_gave_reg <= 1'b1;
                        state_reg    <= S_FIN;
                    end else begin
                        idx_reg   <= '0;
                        sel_reg   <= 1'b1;
                        state_reg <= S_SUP_RD;
                    end
                end
                S_SUP_RD: state_reg <= S_SUP_MX;
                S_SUP_MX: begin
                    acc_reg <= mac; state_reg <= S_SUP_MY;
                end
                S_SUP_MY: begin
                    if (take_best) bdot_reg <= mac;
                    bx_reg <= bx_new;
                    by_reg <= by_new;
                    if (last_vert) begin
                        idx_reg <= '0;
                        if (sel_reg) begin
                            sup2x_reg <= bx_new;
                            sup2y_reg <= by_new;
                            sel_reg   <= 1'b0;
                            state_reg <= S_SUP_RD;
                        end else begin
                            px_reg    <= PW'(sup2x_reg) - PW'(bx_new);
                            py_reg    <= PW'(sup2y_reg) - PW'(by_new);
                            state_reg <= S_PCHK;
                        end
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SUP_RD;
                    end
                end
                S_PCHK: begin
                    if (px_reg == '0 && py_reg == '0) begin
                        res_ovl_reg  <= 1'b1;
                        res_gave_reg <= 1'b0;
                        state_reg    <= S_FIN;
                    end else if (first_reg) begin
                        first_reg <= 1'b0;
                        p0x_reg   <= px_reg;
                        p0y_reg   <= py_reg;
                        ssize_reg <= 2'd1;
                        dx_reg    <= -DW'(px_reg);
                        dy_reg    <= -DW'(py_reg);
                        iter_reg  <= '0;
                        state_reg <= S_IT;
                    end else begin
                        state_reg <= S_DOT0;
                    end
                end
                S_DOT0: begin
                    acc_reg <= mac; state_reg <= S_DOT1;
                end
                S_DOT1: begin
                    if (mac_neg) begin
                        res_ovl_reg  <= 1'b0;
                        res_gave_reg <= 1'b0;
                        state_reg    <= S_FIN;
                    end else if (ssize_reg == 2'd1) begin
                        p1x_reg   <= px_reg;
                        p1y_reg   <= py_reg;
                        ssize_reg <= 2'd2;
                        state_reg <= S_LN0;
                    end else begin
                        p2x_reg   <= px_reg;
                        p2y_reg   <= py_reg;
                        ssize_reg <= 2'd3;
                        state_reg <= S_TR0;
                    end
                end
                S_LN0: begin
                    abx_reg   <= EW'(p0x_reg) - EW'(p1x_reg);
                    aby_reg   <= EW'(p0y_reg) - EW'(p1y_reg);
                    state_reg <= S_LN1;
                end
                S_LN1: begin
                    acc_reg <= mac; state_reg <= S_LN2;
                end
                S_LN2: begin
                    // origin on the segment
                    if (mac_zero) begin
                        res_ovl_reg  <= 1'b1;
                        res_gave_reg <= 1'b0;
                        state_reg    <= S_FIN;
                    end else begin
                        dx_reg    <= mac_pos ? -DW'(aby_reg) : DW'(aby_reg);
                        dy_reg    <= mac_pos ? DW'(abx_reg) : -DW'(abx_reg);
                        iter_reg  <= iter_reg + 1'b1;
                        state_reg <= S_IT;
                    end
                end
                S_TR0: begin
                    abx_reg <= t_abx; aby_reg <= t_aby;
                    acx_reg <= t_acx; acy_reg <= t_acy;
                    ux_reg  <= -t_aby; uy_reg <= t_abx;
                    vx_reg  <= -t_acy; vy_reg <= t_acx;
                    state_reg <= S_TR1;
                end
                S_TR1: begin
                    acc_reg <= mac; state_reg <= S_TR2;
                end
                S_TR2: begin
                    if (mac_pos) begin
                        ux_reg <= -ux_reg; uy_reg <= -uy_reg;
                    end
                    state_reg <= S_TR3;
                end
                S_TR3: begin
                    acc_reg <= mac; state_reg <= S_TR4;
                end
                S_TR4: begin
                    if (mac_pos) begin
                        vx_reg <= -vx_reg; vy_reg <= -vy_reg;
                    end
                    state_reg <= S_TR5;
                end
                S_TR5: begin
                    acc_reg <= mac; state_reg <= S_TR6;
                end
                S_TR6: begin
                    if (mac_pos) begin
                        p0x_reg   <= p1x_reg; p0y_reg <= p1y_reg;
                        p1x_reg   <= p2x_reg; p1y_reg <= p2y_reg;
                        ssize_reg <= 2'd2;
                        dx_reg    <= DW'(ux_reg);
                        dy_reg    <= DW'(uy_reg);
                        iter_reg  <= iter_reg + 1'b1;
                        state_reg <= S_IT;
                    end else begin
                        state_reg <= S_TR7;
                    end
                end
                S_TR7: begin
                    acc_reg <= mac; state_reg <= S_TR8;
                end
                S_TR8: begin
                    if (mac_pos) begin
                        p1x_reg   <= p2x_reg; p1y_reg <= p2y_reg;
                        ssize_reg <= 2'd2;
                        dx_reg    <= DW'(vx_reg);
                        dy_reg    <= DW'(vy_reg);
                        iter_reg  <= iter_reg + 1'b1;
                        state_reg <= S_IT;
                    end else begin
                        // origin inside the triangle
                        res_ovl_reg  <= 1'b1;
                        res_gave_reg <= 1'b0;
                        state_reg    <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {dropped_reg, res_gave_reg, res_ovl_reg};
                        cnt1_reg    <= '0;
                        cnt2_reg    <= '0;
                        dropped_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_both: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("overlap and gave_up both set");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt1_reg <= CW'(MAX_VERTS)) && (cnt2_reg <= CW'(MAX_VERTS)))
        else $error("vertex count beyond capacity");

    a_iter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_reg <= IW'(MAX_ITER))
        else $error("iteration count beyond limit");

    a_tri_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TR0) |-> (ssize_reg == 2'd3))
        else $error("triangle step without three points");

    a_fin_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && (!m_valid_reg || m_tready)) |=>
            (m_tvalid && cnt1_reg == '0 && cnt2_reg == '0))
        else $error("result not posted or counts not cleared");

endmodule

// File: verif/gjk_convex_polygon_overlap_core_test.sv
module gjk_convex_polygon_overlap_core_test;
    import gjk_pkg::*;

    localparam int NVERTS = MAX_VERTS_DEF;
    localparam int NITER = MAX_ITER_DEF;
    localparam int CYCLE_LIMIT = 4000000;

    // overlap sits in the lowest bit, as on m_tdata
    typedef struct packed {
        logic dropped;
        logic gave_up;
        logic overlap;
    } verdict_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    gjk_convex_polygon_overlap_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #4 aclk = ~aclk;

    // predictor state
    longint shape_a_x[NVERTS], shape_a_y[NVERTS];
    longint shape_b_x[NVERTS], shape_b_y[NVERTS];
    int count_a, count_b;
    bit lost_vertex;
    verdict_t pending_verdicts[$];

    int mismatches = 0;
    int cycles = 0;
    bit quiet_tail = 0;
    bit sink_gaps = 1;

    function automatic void pick_support(input bit second, input longint dx,
                                         input longint dy, output longint ox,
                                         output longint oy);
        int n;
        int best;
        longint bd;
        longint t;
        n = second ? count_b : count_a;
        best = 0;
        bd = second ? dx * shape_b_x[0] + dy * shape_b_y[0]
                    : dx * shape_a_x[0] + dy * shape_a_y[0];
        for (int i = 1; i < n; i++) begin
            t = second ? dx * shape_b_x[i] + dy * shape_b_y[i]
                       : dx * shape_a_x[i] + dy * shape_a_y[i];
            if (t > bd) begin
                bd = t;
                best = i;
            end
        end
        ox = second ? shape_b_x[best] : shape_a_x[best];
        oy = second ? shape_b_y[best] : shape_a_y[best];
    endfunction

    function automatic void minkowski_point(input longint dx, input longint dy,
                                            output longint px, output longint py);
        longint ax, ay, bx, by;
        pick_support(1'b1, dx, dy, ax, ay);
        pick_support(1'b0, -dx, -dy, bx, by);
        px = ax - bx;
        py = ay - by;
    endfunction

    function automatic bit polygons_touch(output bit gave);
        longint s1x, s1y, s2x, s2y, dx, dy, px, py;
        longint sx[3], sy[3];
        longint ax, ay, abx, aby, acx, acy, ux, uy, wx, wy, cr;
        int n;
        gave = 0;
        s1x = 0; s1y = 0; s2x = 0; s2y = 0;
        if (count_a == 0 || count_b == 0) return 0;
        for (int i = 0; i < count_a; i++) begin
            s1x += shape_a_x[i];
            s1y += shape_a_y[i];
        end
        for (int i = 0; i < count_b; i++) begin
            s2x += shape_b_x[i];
            s2y += shape_b_y[i];
        end
        dx = count_a * s2x - count_b * s1x;
        dy = count_a * s2y - count_b * s1y;
        if (dx == 0 && dy == 0) dx = 1;
        minkowski_point(dx, dy, px, py);
        sx[0] = px; sy[0] = py; n = 1;
        if (px == 0 && py == 0) return 1;
        dx = -px; dy = -py;
        for (int it = 0; it < NITER; it++) begin
            minkowski_point(dx, dy, px, py);
            if (px == 0 && py == 0) return 1;
            if (px * dx + py * dy < 0) return 0;
            sx[n] = px; sy[n] = py; n++;
            if (n == 2) begin
                ax = sx[1]; ay = sy[1];
                abx = sx[0] - ax; aby = sy[0] - ay;
                cr = abx * (-ay) - aby * (-ax);
                if (cr == 0) return 1;
                dx = cr > 0 ? -aby : aby;
                dy = cr > 0 ? abx : -abx;
            end else begin
                ax = sx[2]; ay = sy[2];
                abx = sx[1] - ax; aby = sy[1] - ay;
                acx = sx[0] - ax; acy = sy[0] - ay;
                ux = -aby; uy = abx; wx = -acy; wy = acx;
                if (ux * acx + uy * acy > 0) begin ux = -ux; uy = -uy; end
                if (wx * abx + wy * aby > 0) begin wx = -wx; wy = -wy; end
                if (ux * (-ax) + uy * (-ay) > 0) begin
                    sx[0] = sx[1]; sy[0] = sy[1];
                    sx[1] = ax; sy[1] = ay;
                    n = 2;
                    dx = ux; dy = uy;
                end else if (wx * (-ax) + wy * (-ay) > 0) begin
                    sx[1] = ax; sy[1] = ay;
                    n = 2;
                    dx = wx; dy = wy;
                end else begin
                    return 1;
                end
            end
        end
        gave = 1;
        return 0;
    endfunction

    function automatic void predict_item(input opcode_t op, input logic [15:0] x,
                                         input logic [15:0] y);
        verdict_t v;
        bit gave;
        if (op == OP_ADD_FIRST) begin
            if (count_a < NVERTS) begin
                shape_a_x[count_a] = longint'($signed(x));
                shape_a_y[count_a] = longint'($signed(y));
                count_a++;
            end else lost_vertex = 1;
        end else if (op == OP_ADD_SECOND) begin
            if (count_b < NVERTS) begin
                shape_b_x[count_b] = longint'($signed(x));
                shape_b_y[count_b] = longint'($signed(y));
                count_b++;
            end else lost_vertex = 1;
        end else if (op == OP_CHECK) begin
            v.overlap = polygons_touch(gave);
            v.gave_up = gave;
            v.dropped = lost_vertex;
            pending_verdicts = {pending_verdicts, v};
            count_a = 0;
            count_b = 0;
            lost_vertex = 0;
        end
    endfunction

    // one transaction on the input channel, with random gaps before it;
    // tvalid stays high after the accept until the next call or the end of the run
    task automatic send_item(input opcode_t op, input logic [15:0] x, input logic [15:0] y);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, y, x, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_item(op, x, y);
    endtask

    task automatic send_vertex(input bit second, input int x, input int y);
        send_item(second ? OP_ADD_SECOND : OP_ADD_FIRST, 16'(x), 16'(y));
    endtask

    task automatic send_check();
        send_item(OP_CHECK, 16'($urandom), 16'($urandom));
    endtask

    // sink stalls
    initial begin
        int len;
        forever begin
            @(posedge aclk);
            if (quiet_tail || !sink_gaps) m_tready <= 1'b1;
            else if ($urandom_range(0, 3) == 0) begin
                len = $urandom_range(1, 13);
                m_tready <= 1'b0;
                repeat (len) @(posedge aclk);
                m_tready <= 1'b1;
            end else m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        verdict_t want;
        verdict_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[2:0];
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction on m_: %b", m_tdata);
            end else begin
                want = pending_verdicts.pop_front();
                if (got.overlap !== want.overlap || got.gave_up !== want.gave_up ||
                    got.dropped !== want.dropped) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected ov=%0b gu=%0b dr=%0b got ov=%0b gu=%0b dr=%0b",
                                 want.overlap, want.gave_up, want.dropped,
                                 got.overlap, got.gave_up, got.dropped);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("gjk_convex_polygon_overlap_core verification failed");
            $finish;
        end
    end

    task automatic square(input bit second, input int cx, input int cy, input int r);
        send_vertex(second, cx - r, cy - r);
        send_vertex(second, cx + r, cy - r);
        send_vertex(second, cx + r, cy + r);
        send_vertex(second, cx - r, cy + r);
    endtask

    task automatic test_directed();
        // empty shapes
        send_check();
        send_vertex(0, 5, 5);
        send_check();
        // overlapping and apart squares
        square(0, 0, 0, 10);
        square(1, 5, 5, 10);
        send_check();
        square(0, 0, 0, 10);
        square(1, 100, 0, 10);
        send_check();
        // same point both shapes: support at origin
        send_vertex(0, 7, 7);
        send_vertex(1, 7, 7);
        send_check();
        // extremes of the coordinates
        send_vertex(0, -32768, -32768);
        send_vertex(0, 32767, -32768);
        send_vertex(0, 0, 32767);
        send_vertex(1, 32767, 32767);
        send_vertex(1, -32768, 32767);
        send_check();
        // full store drops vertices, and a no-op opcode
        for (int i = 0; i < NVERTS + 2; i++) send_vertex(0, i * 3, i * i);
        send_item(OP_NONE, 16'hffff, 16'hffff);
        send_vertex(1, 1, 1);
        send_check();
    endtask

    task automatic random_polygon(input bit second, input bit tiny);
        int n, cx, cy, r, a;
        n = $urandom_range(1, 7);
        if ($urandom_range(0, 15) == 0) n = $urandom_range(NVERTS, NVERTS + 3);
        r = tiny ? $urandom_range(0, 8) : $urandom_range(1, 12000);
        cx = tiny ? $urandom_range(0, 16) - 8 : $urandom_range(0, 40000) - 20000;
        cy = tiny ? $urandom_range(0, 16) - 8 : $urandom_range(0, 40000) - 20000;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                send_vertex(second, $urandom, $urandom);
            end else begin
                // points on a rough diamond keep most shapes convex
                a = i % 4;
                case (a)
                    0: send_vertex(second, cx + r, cy + i);
                    1: send_vertex(second, cx - i, cy + r);
                    2: send_vertex(second, cx - r, cy - i);
                    default: send_vertex(second, cx + i, cy - r);
                endcase
            end
        end
    endtask

    task automatic test_random(input int items);
        int sent;
        bit tiny;
        sent = 0;
        while (sent < items) begin
            tiny = $urandom_range(0, 2) == 0;
            random_polygon(0, tiny);
            random_polygon(1, tiny);
            if ($urandom_range(0, 19) == 0)
                send_item(OP_NONE, 16'($urandom), 16'($urandom));
            send_check();
            sent += 11;
        end
    endtask

    initial begin
        count_a = 0;
        count_b = 0;
        lost_vertex = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(1250);
        quiet_tail = 1;
        test_random(200);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("gjk_convex_polygon_overlap_core verification clean");
        else
            $display("gjk_convex_polygon_overlap_core verification failed");
        $finish;
    end
endmodule
